// File: hdl/kf3_pkg.sv
// ----------------------------------------------------------------------------
// kf3_pkg
// Shared widths, constants and types of the three-axis Kalman filter.
// ----------------------------------------------------------------------------
package kf3_pkg;

    localparam int AXES      = 3;
    localparam int DIST_W    = 16;
    localparam int EST_W     = 24;
    localparam int VAR_W     = 32;
    localparam int GAIN_W    = 17;
    localparam int FRAC_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // Register map
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_VAR_BASE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_VAR_BASE    = CFG_IDX_W'(AXES);

    localparam logic [VAR_W-1:0] PROCESS_VAR_INIT = VAR_W'(655);
    localparam logic [VAR_W-1:0] MEAS_VAR_INIT    = VAR_W'(655);
    localparam logic [VAR_W-1:0] VARIANCE_INIT    = VAR_W'(65536);

    localparam logic [EST_W-1:0] EST_INIT_0 = EST_W'(2000 * 256);
    localparam logic [EST_W-1:0] EST_INIT_1 = EST_W'(4000 * 256);
    localparam logic [EST_W-1:0] EST_INIT_2 = EST_W'(5000 * 256);

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);
    localparam int                ROUND_HALF = 32768;

    typedef struct packed {
        logic idle;
        logic done;
    } kf3_lane_stat_t;

endpackage

// File: hdl/kf3_if.sv
// ----------------------------------------------------------------------------
// kf3 channel interfaces
// Measurement, estimate and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface kf3_meas_if;
    logic                        valid;
    logic                        ready;
    logic [kf3_pkg::DIST_W-1:0]  dist_0;
    logic [kf3_pkg::DIST_W-1:0]  dist_1;
    logic [kf3_pkg::DIST_W-1:0]  dist_2;

    modport source (output valid, output dist_0, output dist_1, output dist_2, input ready);
    modport sink   (input valid, input dist_0, input dist_1, input dist_2, output ready);
endinterface

interface kf3_est_if;
    logic                       valid;
    logic                       ready;
    logic [kf3_pkg::EST_W-1:0]  filt_0;
    logic [kf3_pkg::EST_W-1:0]  filt_1;
    logic [kf3_pkg::EST_W-1:0]  filt_2;

    modport source (output valid, output filt_0, output filt_1, output filt_2, input ready);
    modport sink   (input valid, input filt_0, input filt_1, input filt_2, output ready);
endinterface

interface kf3_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [kf3_pkg::CFG_IDX_W-1:0]  index;
    logic [kf3_pkg::CFG_DAT_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/kf3_lane.sv
// ----------------------------------------------------------------------------
// kf3_lane
// One axis: predict, serial gain division, blend of estimate and variance.
// ----------------------------------------------------------------------------
module kf3_lane #(
    parameter logic [kf3_pkg::EST_W-1:0] ESTIMATE_INIT = kf3_pkg::EST_INIT_0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          ack,
    input  logic [kf3_pkg::DIST_W-1:0]    z_in,
    input  logic [kf3_pkg::VAR_W-1:0]     q,
    input  logic [kf3_pkg::VAR_W-1:0]     r,
    output logic [kf3_pkg::EST_W-1:0]     filt,
    output kf3_pkg::kf3_lane_stat_t       stat
);
    import kf3_pkg::*;

    localparam int CNT_W   = $clog2(GAIN_W);
    localparam int REM_W   = VAR_W + 2;
    localparam int PE_W    = EST_W + GAIN_W;
    localparam int PP_W    = VAR_W + GAIN_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_ACC   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [EST_W-1:0]    est_reg;
    logic [VAR_W-1:0]    var_reg;

    logic [VAR_W-1:0]    pp_reg;
    logic [VAR_W:0]      s_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [GAIN_W-1:0]   k_reg;
    logic [DIST_W-1:0]   z_reg;
    logic [PE_W-1:0]     prod_e_reg;
    logic [PE_W-1:0]     prod_z_reg;
    logic [PP_W-1:0]     prod_p_reg;

    logic [VAR_W:0]      pp_sum;
    logic [VAR_W-1:0]    pp_sat;
    logic [REM_W-1:0]    trial;
    logic                ge;
    logic [GAIN_W-1:0]   k_fin;
    logic [GAIN_W-1:0]   inv;
    logic [PE_W:0]       e_sum;
    logic [PP_W-1:0]     p_sum;

    assign pp_sum = {1'b0, var_reg} + {1'b0, q};
    assign pp_sat = pp_sum[VAR_W] ? '1 : pp_sum[VAR_W-1:0];
    assign trial  = (cnt_reg == '0) ? rem_reg : {rem_reg[REM_W-2:0], 1'b0};
    assign ge     = trial >= {1'b0, s_reg};
    assign k_fin  = (s_reg == '0) ? '0 : k_reg;
    assign inv    = GAIN_ONE - k_fin;
    assign e_sum  = {1'b0, prod_e_reg} + {1'b0, prod_z_reg} + (PE_W + 1)'(ROUND_HALF);
    assign p_sum  = prod_p_reg + PP_W'(ROUND_HALF);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (start) state_next = ST_SETUP;
            ST_SETUP: state_next = ST_DIV;
            ST_DIV:   if (cnt_reg == CNT_W'(GAIN_W - 1)) state_next = ST_MUL;
            ST_MUL:   state_next = ST_ACC;
            ST_ACC:   state_next = ST_DONE;
            ST_DONE:  if (ack) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            est_reg   <= ESTIMATE_INIT;
            var_reg   <= VARIANCE_INIT;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SETUP)
                cnt_reg <= '0;
            else if (state_reg == ST_DIV)
                cnt_reg <= cnt_reg + CNT_W'(1);
            if (state_reg == ST_ACC)
            begin
                est_reg <= e_sum[FRAC_W +: EST_W];
                var_reg <= p_sum[FRAC_W +: VAR_W];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            pp_reg <= pp_sat;
            z_reg  <= z_in;
        end
        if (state_reg == ST_SETUP)
        begin
            s_reg   <= {1'b0, pp_reg} + {1'b0, r};
            rem_reg <= {2'b00, pp_reg};
            k_reg   <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            rem_reg <= ge ? trial - {1'b0, s_reg} : trial;
            k_reg   <= {k_reg[GAIN_W-2:0], ge};
        end
        if (state_reg == ST_MUL)
        begin
            prod_e_reg <= est_reg * inv;
            prod_z_reg <= {z_reg, 8'h00} * k_fin;
            prod_p_reg <= pp_reg * inv;
        end
    end

    assign filt      = est_reg;
    assign stat.idle = (state_reg == ST_IDLE);
    assign stat.done = (state_reg == ST_DONE);

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && s_reg != '0) |-> (rem_reg < {s_reg, 1'b0}))
        else $error("divider remainder out of range");

    a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (k_fin <= GAIN_ONE))
        else $error("gain above one");

    a_var_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC) |=> (var_reg <= pp_reg))
        else $error("variance grew in update");

endmodule

// File: hdl/kf3_merge.sv
// ----------------------------------------------------------------------------
// kf3_merge
// Combine lane results into one estimate word and hold it for the receiver.
// ----------------------------------------------------------------------------
module kf3_merge (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kf3_pkg::kf3_lane_stat_t       stat [kf3_pkg::AXES],
    input  logic [kf3_pkg::EST_W-1:0]     filt [kf3_pkg::AXES],
    output logic                          ack,
    output logic                          all_idle,
    kf3_est_if.source                     est
);
    import kf3_pkg::*;

    logic [AXES-1:0]    done_vec;
    logic [AXES-1:0]    idle_vec;
    logic               valid_reg;
    logic [EST_W-1:0]   filt_reg [AXES];
    logic               load;

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            done_vec[i] = stat[i].done;
            idle_vec[i] = stat[i].idle;
        end
    end

    assign load     = (&done_vec) && (!valid_reg || est.ready);
    assign ack      = load;
    assign all_idle = &idle_vec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (est.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            for (int i = 0; i < AXES; i++)
                filt_reg[i] <= filt[i];
    end

    assign est.valid  = valid_reg;
    assign est.filt_0 = filt_reg[0];
    assign est.filt_1 = filt_reg[1];
    assign est.filt_2 = filt_reg[2];

    a_lock_done: assert property (@(posedge clk) disable iff (!rst_n)
        (|done_vec) |-> (&done_vec))
        else $error("lanes finished out of step");

    a_lock_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (|idle_vec) |-> (&idle_vec))
        else $error("lanes started out of step");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg)
        else $error("merged word lost");

endmodule

// File: hdl/kalman_filter_3axis.sv
// ----------------------------------------------------------------------------
// kalman_filter_3axis
// Three scalar Kalman filters, one per ranging anchor, with shared sequencing.
//
// Channels: meas takes one word of three distances in mm; est returns one
// word of three filtered distances in unsigned Q16.8 mm per measurement word;
// cfg writes the process variances (index 0..2) and measurement variances
// (index 3..5), Q16.16. Writes to other indexes are dropped; cfg is always
// ready. Write cfg only while no measurement is in flight.
// Path from meas acceptance to est valid: the predicted variance is taken
// at acceptance, then a setup step, the restoring gain divider, a multiply
// step, an accumulate step and the load of the output register. A new word
// is not accepted while the previous one is still in the lanes, which is
// set by the serial divider in each lane; all three lanes run in lockstep.
// meas.ready is high while the lanes are idle. A result waiting in the
// output register does not block acceptance; if the receiver still stalls
// when the next result is done, the lanes hold it until est frees up.
// Reset: estimates go to 2000, 4000, 5000 mm, variances to 1.0, all
// noise variances to 655 (about 0.01).
// ----------------------------------------------------------------------------
module kalman_filter_3axis (
    input  logic        clk,
    input  logic        rst_n,
    kf3_meas_if.sink    meas,
    kf3_est_if.source   est,
    kf3_cfg_if.sink     cfg
);
    import kf3_pkg::*;

    logic [VAR_W-1:0]    q_reg [AXES];
    logic [VAR_W-1:0]    r_reg [AXES];
    logic [DIST_W-1:0]   dist_a [AXES];
    logic [EST_W-1:0]    filt_a [AXES];
    kf3_lane_stat_t      stat_a [AXES];
    logic                start;
    logic                ack;
    logic                all_idle;

    assign cfg.ready  = 1'b1;
    assign meas.ready = all_idle;
    assign start      = meas.valid && all_idle;

    assign dist_a[0] = meas.dist_0;
    assign dist_a[1] = meas.dist_1;
    assign dist_a[2] = meas.dist_2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                q_reg[i] <= PROCESS_VAR_INIT;
                r_reg[i] <= MEAS_VAR_INIT;
            end
        end
        else if (cfg.valid)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                if (cfg.index == CFG_PROCESS_VAR_BASE + CFG_IDX_W'(i))
                    q_reg[i] <= cfg.data;
                if (cfg.index == CFG_MEAS_VAR_BASE + CFG_IDX_W'(i))
                    r_reg[i] <= cfg.data;
            end
        end
    end

    localparam logic [EST_W-1:0] EST_INIT_A [AXES] = '{EST_INIT_0, EST_INIT_1, EST_INIT_2};

    for (genvar g = 0; g < AXES; g++)
    begin : g_lane
        kf3_lane #(
            .ESTIMATE_INIT (EST_INIT_A[g])
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .start (start),
            .ack   (ack),
            .z_in  (dist_a[g]),
            .q     (q_reg[g]),
            .r     (r_reg[g]),
            .filt  (filt_a[g]),
            .stat  (stat_a[g])
        );
    end

    kf3_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .stat     (stat_a),
        .filt     (filt_a),
        .ack      (ack),
        .all_idle (all_idle),
        .est      (est)
    );

endmodule

// File: tb/tb_kalman_filter_3axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kalman_filter_3axis
// Self-checking bench for the three-axis Kalman filter. A table of directed
// words covers reset state, field extremes, zero and saturated variances and
// unmapped register writes. Random phases follow with new noise settings and
// different valid/ready idling, plus one long output hold-off. Estimates are
// checked per axis against a fixed-point filter model or typed table values.
// ----------------------------------------------------------------------------
module tb_kalman_filter_3axis;
    import kf3_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 12;
    localparam int DUT_LATENCY     = 21;
    localparam int TIMEOUT_CYCLES  = 1_000_000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int EST_FRAC        = 8;
    localparam int DIST_MAX        = (1 << DIST_W) - 1;
    localparam int DIR_ROWS        = 38;

    typedef logic [DIST_W-1:0]              dist_t;
    typedef logic [EST_W-1:0]               est_t;
    typedef logic [VAR_W-1:0]               var_t;
    typedef logic [CFG_IDX_W-1:0]           cfg_idx_t;
    typedef logic [AXES-1:0][DIST_W-1:0]    dist_word_t;
    typedef logic [AXES-1:0][EST_W-1:0]     est_word_t;

    localparam cfg_idx_t IDX_PROC_0     = CFG_PROCESS_VAR_BASE;
    localparam cfg_idx_t IDX_PROC_1     = cfg_idx_t'(CFG_PROCESS_VAR_BASE + 1);
    localparam cfg_idx_t IDX_PROC_2     = cfg_idx_t'(CFG_PROCESS_VAR_BASE + 2);
    localparam cfg_idx_t IDX_MEAS_0     = CFG_MEAS_VAR_BASE;
    localparam cfg_idx_t IDX_MEAS_1     = cfg_idx_t'(CFG_MEAS_VAR_BASE + 1);
    localparam cfg_idx_t IDX_MEAS_2     = cfg_idx_t'(CFG_MEAS_VAR_BASE + 2);
    localparam cfg_idx_t IDX_UNMAPPED_A = cfg_idx_t'(CFG_MEAS_VAR_BASE + AXES);
    localparam cfg_idx_t IDX_UNMAPPED_B = cfg_idx_t'(CFG_MEAS_VAR_BASE + AXES + 1);

    localparam var_t VAR_ZERO = '0;
    localparam var_t VAR_MAX  = '1;
    localparam var_t VAR_MIN  = var_t'(1);

    typedef enum logic { ROW_WRITE, ROW_MEAS } row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        cfg_idx_t  idx;
        var_t      data;
        dist_t     d0;
        dist_t     d1;
        dist_t     d2;
        logic      typed;
        est_t      f0;
        est_t      f1;
        est_t      f2;
    } dir_row_t;

    dir_row_t dir_table [DIR_ROWS] = '{
        '{ROW_MEAS,  '0, '0, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0, '0, '0},
        '{ROW_MEAS,  '0, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0, '0, '0},
        '{ROW_MEAS,  '0, '0, 16'hAAAA, 16'h5555, 16'h1234, 1'b0, '0, '0, '0},
        '{ROW_WRITE, IDX_PROC_0, VAR_ZERO, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, IDX_PROC_1, VAR_ZERO, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, IDX_PROC_2, VAR_ZERO, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, IDX_MEAS_0, VAR_ZERO, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, IDX_MEAS_1, VAR_ZERO, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, IDX_MEAS_2, VAR_ZERO, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_MEAS,  '0, '0, 16'h0000, 16'hFFFF, 16'h8001,
          1'b1, 24'h000000, 24'hFFFF00, 24'h800100},
        '{ROW_MEAS,  '0, '0, 16'hFFFF, 16'h0000, 16'h1234,
          1'b1, 24'h000000, 24'hFFFF00, 24'h800100},
        '{ROW_MEAS,  '0, '0, 16'h5555, 16'hAAAA, 16'h0000,
          1'b1, 24'h000000, 24'hFFFF00, 24'h800100},
        '{ROW_WRITE, IDX_PROC_0, VAR_MAX, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, IDX_PROC_1, VAR_MAX, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, IDX_PROC_2, VAR_MAX, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, IDX_MEAS_0, VAR_MAX, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, IDX_MEAS_1, VAR_MAX, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, IDX_MEAS_2, VAR_MAX, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_MEAS,  '0, '0, 16'hFFFF, 16'h0000, 16'h8000, 1'b0, '0, '0, '0},
        '{ROW_MEAS,  '0, '0, 16'h0000, 16'hFFFF, 16'h7FFF, 1'b0, '0, '0, '0},
        '{ROW_MEAS,  '0, '0, 16'h1234, 16'h4321, 16'hFFFF, 1'b0, '0, '0, '0},
        '{ROW_WRITE, IDX_UNMAPPED_A, VAR_MAX,  '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, IDX_UNMAPPED_B, VAR_ZERO, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, IDX_PROC_0, VAR_MIN, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, IDX_PROC_1, VAR_MIN, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, IDX_PROC_2, VAR_MIN, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, IDX_MEAS_0, VAR_MIN, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, IDX_MEAS_1, VAR_MIN, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, IDX_MEAS_2, VAR_MIN, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_MEAS,  '0, '0, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, '0, '0, '0},
        '{ROW_MEAS,  '0, '0, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, '0, '0, '0},
        '{ROW_WRITE, IDX_PROC_0, PROCESS_VAR_INIT, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, IDX_PROC_1, PROCESS_VAR_INIT, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, IDX_PROC_2, PROCESS_VAR_INIT, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, IDX_MEAS_0, MEAS_VAR_INIT,    '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, IDX_MEAS_1, MEAS_VAR_INIT,    '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, IDX_MEAS_2, MEAS_VAR_INIT,    '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_MEAS,  '0, '0, 16'd2000, 16'd4000, 16'd5000, 1'b0, '0, '0, '0}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    kf3_meas_if meas ();
    kf3_est_if  est ();
    kf3_cfg_if  cfg ();

    kalman_filter_3axis u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .meas  (meas),
        .est   (est),
        .cfg   (cfg)
    );

    est_t      filt_est [AXES];
    var_t      filt_var [AXES];
    var_t      proc_q   [AXES];
    var_t      meas_r   [AXES];
    est_word_t pending_est [$];

    int mismatch_cnt   = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic est_word_t filter_update(input dist_word_t z);
        est_word_t   w;
        logic [63:0] pp;
        logic [63:0] s;
        logic [63:0] k;
        logic [63:0] inv;
        logic [63:0] ne;
        logic [63:0] np;
        for (int a = 0; a < AXES; a++)
        begin
            pp = 64'(filt_var[a]) + 64'(proc_q[a]);
            if (pp > 64'(VAR_MAX))
            begin
                pp = 64'(VAR_MAX);
            end
            s = pp + 64'(meas_r[a]);
            k = (s == 64'd0) ? 64'd0 : (pp << FRAC_W) / s;
            if (k > 64'(GAIN_ONE))
            begin
                k = 64'(GAIN_ONE);
            end
            inv = 64'(GAIN_ONE) - k;
            ne  = (64'(filt_est[a]) * inv + (64'(z[a]) << EST_FRAC) * k
                   + 64'(ROUND_HALF)) >> FRAC_W;
            np  = (pp * inv + 64'(ROUND_HALF)) >> FRAC_W;
            filt_est[a] = ne[EST_W-1:0];
            filt_var[a] = np[VAR_W-1:0];
            w[a]        = filt_est[a];
        end
        return w;
    endfunction

    function automatic dist_word_t rand_dist();
        dist_word_t z;
        int         centre;
        for (int a = 0; a < AXES; a++)
        begin
            case ($urandom_range(19))
                0: z[a] = '0;
                1: z[a] = '1;
                2, 3, 4, 5, 6: z[a] = dist_t'($urandom);
                default:
                begin
                    centre = int'(filt_est[a] >> EST_FRAC) + int'($urandom_range(400)) - 200;
                    if (centre < 0)
                    begin
                        centre = 0;
                    end
                    else if (centre > DIST_MAX)
                    begin
                        centre = DIST_MAX;
                    end
                    z[a] = dist_t'(centre);
                end
            endcase
        end
        return z;
    endfunction

    function automatic var_t rand_var(input bit for_meas);
        case ($urandom_range(9))
            0: return for_meas ? var_t'($urandom_range(1)) : VAR_ZERO;
            1: return VAR_MAX;
            2, 3, 4, 5: return var_t'($urandom_range(4000));
            6, 7: return var_t'($urandom_range(1 << 20));
            default: return var_t'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_est.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input cfg_idx_t idx, input var_t val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg.ready);
        if (idx < CFG_MEAS_VAR_BASE)
        begin
            proc_q[idx - CFG_PROCESS_VAR_BASE] = val;
        end
        else if (idx < CFG_MEAS_VAR_BASE + AXES)
        begin
            meas_r[idx - CFG_MEAS_VAR_BASE] = val;
        end
    endtask

    task automatic send_meas(input dist_word_t z, input bit use_typed, input est_word_t typed_w);
        est_word_t w;
        while ($urandom_range(99) < send_idle_pct)
        begin
            meas.valid <= 1'b0;
            @(posedge clk);
        end
        meas.valid  <= 1'b1;
        meas.dist_0 <= z[0];
        meas.dist_1 <= z[1];
        meas.dist_2 <= z[2];
        do
        begin
            @(posedge clk);
        end
        while (!meas.ready);
        w = filter_update(z);
        pending_est.push_back(use_typed ? typed_w : w);
    endtask

    task automatic run_phase(input int n, input int send_pct, input int recv_pct, input int hold);
        meas.valid <= 1'b0;
        wait_drained();
        for (int a = 0; a < AXES; a++)
        begin
            write_reg(CFG_PROCESS_VAR_BASE + cfg_idx_t'(a), rand_var(1'b0));
            write_reg(CFG_MEAS_VAR_BASE + cfg_idx_t'(a), rand_var(1'b1));
        end
        if ($urandom_range(3) == 0)
        begin
            write_reg($urandom_range(1) ? IDX_UNMAPPED_B : IDX_UNMAPPED_A, var_t'($urandom));
        end
        cfg.valid <= 1'b0;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        hold_left      = hold;
        repeat (n)
        begin
            send_meas(rand_dist(), 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        est_word_t got;
        est_word_t want;
        if (rst_n)
        begin
            if (est.valid && est.ready)
            begin
                got = {est.filt_2, est.filt_1, est.filt_0};
                if (pending_est.size() == 0)
                begin
                    $display("%0t unexpected estimate word expected none actual %h",
                             $time, got);
                    mismatch_cnt++;
                end
                else
                begin
                    want = pending_est.pop_front();
                    for (int a = 0; a < AXES; a++)
                    begin
                        if (got[a] !== want[a])
                        begin
                            $display("%0t filt_%0d expected %h actual %h",
                                     $time, a, want[a], got[a]);
                            mismatch_cnt++;
                        end
                    end
                end
            end
            if (hold_left > 0)
            begin
                est.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                est.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial
    begin
        meas.valid  = 1'b0;
        meas.dist_0 = '0;
        meas.dist_1 = '0;
        meas.dist_2 = '0;
        cfg.valid   = 1'b0;
        cfg.index   = '0;
        cfg.data    = '0;
        est.ready   = 1'b0;

        for (int a = 0; a < AXES; a++)
        begin
            proc_q[a]   = PROCESS_VAR_INIT;
            meas_r[a]   = MEAS_VAR_INIT;
            filt_var[a] = VARIANCE_INIT;
        end
        filt_est[0] = EST_INIT_0;
        filt_est[1] = EST_INIT_1;
        filt_est[2] = EST_INIT_2;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[i])
        begin
            if (dir_table[i].kind == ROW_WRITE)
            begin
                meas.valid <= 1'b0;
                wait_drained();
                write_reg(dir_table[i].idx, dir_table[i].data);
            end
            else
            begin
                cfg.valid <= 1'b0;
                send_meas({dir_table[i].d2, dir_table[i].d1, dir_table[i].d0},
                          dir_table[i].typed,
                          {dir_table[i].f2, dir_table[i].f1, dir_table[i].f0});
            end
        end

        run_phase(200, 0, 0, 0);
        run_phase(200, 72, 0, 0);
        run_phase(200, 0, 72, 0);
        run_phase(200, 9, 9, 0);
        run_phase(100, 0, 0, HOLD_OFF_CYCLES);
        run_phase(150, 0, 0, 0);
        run_phase(150, 72, 0, 0);
        run_phase(150, 0, 72, 0);

        meas.valid <= 1'b0;
        recv_stall_pct = 0;
        wait_drained();
        repeat (4 * DUT_LATENCY) @(posedge clk);

        if (mismatch_cnt == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
